@@ src/adjacency_matrix_neighbor_scan_assert.svh @@
// Assertion macros for the neighbour scan block.
`ifndef ADJACENCY_MATRIX_NEIGHBOR_SCAN_ASSERT_SVH
`define ADJACENCY_MATRIX_NEIGHBOR_SCAN_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define AMNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define AMNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/amns_pkg.sv @@
`timescale 1ns / 1ps

package amns_pkg;

  localparam int VERTEX_W = 4;
  localparam int WEIGHT_W = 16;
  localparam int REQ_W    = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UNDIR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DIR    = 2'd2;

endpackage

@@ src/adjacency_matrix_neighbor_scan.sv @@
`timescale 1ns / 1ps
// Insert: writes the edge weight, no result. Query: one row/column read pair per cycle from
// the two-read-port weight memory unless an output stall holds the scan stage; the input
// stays stalled until the last result is issued. Reset (rst_ni, async, active low) clears
// control state, then a clearing pass writes zero to all VERTICES*VERTICES entries,
// one a cycle, input stalled.

`include "adjacency_matrix_neighbor_scan_assert.svh"

module adjacency_matrix_neighbor_scan
  import amns_pkg::*;
#(
  parameter int VERTICES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic [VERTEX_W-1:0]        from_vertex_i,
  input  logic [VERTEX_W-1:0]        to_vertex_i,
  input  logic signed [WEIGHT_W-1:0] edge_weight_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [VERTEX_W-1:0]        neighbor_vertex_o,
  output logic signed [WEIGHT_W-1:0] neighbor_weight_o,
  output logic                       found_o,
  output logic                       last_o
);

  localparam int VW    = $clog2(VERTICES);
  localparam int DEPTH = VERTICES * VERTICES;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [VW-1:0] J_LAST   = VW'(VERTICES - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] COL_STEP = AW'(VERTICES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  logic signed [WEIGHT_W-1:0] mem [DEPTH];
  logic signed [WEIGHT_W-1:0] rd_row_q, rd_col_q;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic signed [WEIGHT_W-1:0] mem_wdata;
  logic                       rd_en;

  state_e                     state_q, state_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic [AW-1:0]              row_addr_q, row_addr_d;
  logic [AW-1:0]              col_addr_q, col_addr_d;
  logic [VW-1:0]              j_q, j_d;
  logic [VW-1:0]              j2_q, j2_d;
  logic [VW-1:0]              src_q, src_d;
  logic                       dir_q, dir_d;
  logic                       s2_v_q, s2_v_d;
  logic                       pend_v_q, pend_v_d;
  logic [VW-1:0]              pend_j_q, pend_j_d;
  logic signed [WEIGHT_W-1:0] pend_w_q, pend_w_d;
  logic                       out_valid_q, out_valid_d;
  logic [VERTEX_W-1:0]        out_vertex_q, out_vertex_d;
  logic signed [WEIGHT_W-1:0] out_weight_q, out_weight_d;
  logic                       found_q, found_d;
  logic                       last_q, last_d;

  logic                       out_free;
  logic                       hit;
  logic signed [WEIGHT_W-1:0] hit_w;
  logic                       s2_block;
  logic                       src_ok, dst_ok;

  assign out_free = !out_valid_q || !out_stall_i;
  assign src_ok   = 32'(from_vertex_i) < VERTICES;
  assign dst_ok   = 32'(to_vertex_i) < VERTICES;

  // neighbour test on the registered row/column pair
  always_comb begin
    hit   = 1'b0;
    hit_w = rd_row_q;
    if (dir_q) begin
      hit = rd_row_q != '0;
    end else if (j2_q != src_q) begin
      if (rd_col_q != '0) begin
        hit   = 1'b1;
        hit_w = rd_col_q;
      end else begin
        hit = rd_row_q != '0;
      end
    end
  end

  assign s2_block = s2_v_q && hit && pend_v_q && !out_free;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    row_addr_d   = row_addr_q;
    col_addr_d   = col_addr_q;
    j_d          = j_q;
    j2_d         = j2_q;
    src_d        = src_q;
    dir_d        = dir_q;
    s2_v_d       = s2_v_q;
    pend_v_d     = pend_v_q;
    pend_j_d     = pend_j_q;
    pend_w_d     = pend_w_q;
    out_valid_d  = out_valid_q;
    out_vertex_d = out_vertex_q;
    out_weight_d = out_weight_q;
    found_d      = found_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = '0;
    rd_en        = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // a new hit pushes the held one out; the held one is only known last at scan end
    if (s2_v_q && !s2_block) begin
      s2_v_d = 1'b0;
      if (hit) begin
        if (pend_v_q) begin
          out_valid_d  = 1'b1;
          out_vertex_d = VERTEX_W'(pend_j_q);
          out_weight_d = pend_w_q;
          found_d      = 1'b1;
          last_d       = 1'b0;
        end
        pend_v_d = 1'b1;
        pend_j_d = j2_q;
        pend_w_d = hit_w;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_type_i)
            REQ_INSERT: begin
              if (src_ok && dst_ok) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(32'(from_vertex_i) * VERTICES + 32'(to_vertex_i));
                mem_wdata = edge_weight_i;
              end
            end
            REQ_UNDIR, REQ_DIR: begin
              src_d      = VW'(from_vertex_i);
              dir_d      = req_type_i == REQ_DIR;
              j_d        = '0;
              row_addr_d = AW'(32'(from_vertex_i) * VERTICES);
              col_addr_d = AW'(from_vertex_i);
              pend_v_d   = 1'b0;
              state_d    = src_ok ? ST_SCAN : ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!s2_block) begin
          rd_en  = 1'b1;
          s2_v_d = 1'b1;
          j2_d   = j_q;
          if (j_q == J_LAST) begin
            state_d = ST_FLUSH;
          end else begin
            j_d        = j_q + VW'(1);
            row_addr_d = row_addr_q + AW'(1);
            col_addr_d = col_addr_q + COL_STEP;
          end
        end
      end
      ST_FLUSH: begin
        if (!s2_v_q && out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = pend_v_q ? VERTEX_W'(pend_j_q) : '0;
          out_weight_d = pend_v_q ? pend_w_q : '0;
          found_d      = pend_v_q;
          last_d       = 1'b1;
          pend_v_d     = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_row_q <= mem[row_addr_q];
      rd_col_q <= mem[col_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      row_addr_q   <= '0;
      col_addr_q   <= '0;
      j_q          <= '0;
      j2_q         <= '0;
      src_q        <= '0;
      dir_q        <= 1'b0;
      s2_v_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      pend_j_q     <= '0;
      pend_w_q     <= '0;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_weight_q <= '0;
      found_q      <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      row_addr_q   <= row_addr_d;
      col_addr_q   <= col_addr_d;
      j_q          <= j_d;
      j2_q         <= j2_d;
      src_q        <= src_d;
      dir_q        <= dir_d;
      s2_v_q       <= s2_v_d;
      pend_v_q     <= pend_v_d;
      pend_j_q     <= pend_j_d;
      pend_w_q     <= pend_w_d;
      out_valid_q  <= out_valid_d;
      out_vertex_q <= out_vertex_d;
      out_weight_q <= out_weight_d;
      found_q      <= found_d;
      last_q       <= last_d;
    end
  end

  assign in_stall_o        = state_q != ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign neighbor_vertex_o = out_vertex_q;
  assign neighbor_weight_o = out_weight_q;
  assign found_o           = found_q;
  assign last_o            = last_q;

  `AMNS_ASSERT_NOW(a_no_write_in_scan, mem_we,
                   state_q == ST_IDLE || state_q == ST_CLEAR,
                   "memory written during a query")
  `AMNS_ASSERT_NOW(a_s2_only_in_query, s2_v_q,
                   state_q == ST_SCAN || state_q == ST_FLUSH,
                   "scan stage busy outside a query")
  `AMNS_ASSERT_NOW(a_empty_is_last, out_valid_q && !found_q, last_q,
                   "empty result not marked last")
  `AMNS_ASSERT_NEXT(a_flush_to_idle, state_q == ST_FLUSH && !s2_v_q && out_free,
                    state_q == ST_IDLE && out_valid_q && last_q,
                    "final result not issued")

endmodule
